// File: rtl/core/hrh_pkg.sv
// shared types and constants for the hit record histogrammer
`timescale 1ns / 1ps
`default_nettype none
package hrh_pkg;

   localparam int CHANNELS        = 128;
   localparam int CHIP_SLOTS      = 26;
   localparam int AMPLITUDE_STEPS = 64;
   localparam int COUNT_WIDTH     = 16;

   localparam int CHAN_W  = $clog2(CHANNELS) > 0 ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W  = $clog2(CHIP_SLOTS);
   localparam int AMP_W   = $clog2(AMPLITUDE_STEPS) > 0 ? $clog2(AMPLITUDE_STEPS) : 1;
   localparam int DEPTH   = CHIP_SLOTS * CHANNELS * AMPLITUDE_STEPS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CSR_W   = 16;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      CMD_WORD  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CROSS = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_SKIP   = 2'd2,
      KIND_CHECK  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_CHECK  = 2'd2
   } phase_type;

   localparam logic CSR_LEVEL = 1'b0;
   localparam logic CSR_AMPS  = 1'b1;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] word;
      logic [4:0]  query_chip;
      logic [6:0]  query_channel;
      logic [5:0]  query_amplitude;
   } req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic        hit_counted;
      logic [4:0]  chip_id;
      logic        board_id;
      logic [6:0]  channel_id;
      logic [5:0]  amplitude;
      logic [6:0]  crossing_id;
      logic [2:0]  adc_value;
      logic [15:0] count_value;
      logic        found;
      logic [5:0]  crossing_amplitude;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_en;      // clearing pass write
      logic load;          // latch request
      logic rd_issue;      // issue memory read
      logic inc_write;     // write incremented value
      logic search_start;
      logic search_step;   // advance search amplitude
      logic rsp_load;      // build response
      logic frame_update;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       clear_done;
      logic [1:0] command;
      logic       hit;          // word is a countable hit
      logic       search_last;  // last amplitude or out of range
      logic       search_hit;   // read data exceeds level
   } status_type;

endpackage
`default_nettype wire

// File: rtl/core/hrh_stream_if.sv
// valid/ready channel interface
`timescale 1ns / 1ps
`default_nettype none
interface hrh_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/core/hrh_ctrl.sv
// sequencing state machine for the histogrammer
`timescale 1ns / 1ps
`default_nettype none
module hrh_ctrl
   import hrh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type stat,
   output cmd_type         cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_DECODE = 7'b0000100,
      ST_WAIT   = 7'b0001000,
      ST_FINISH = 7'b0010000,
      ST_SEARCH = 7'b0100000,
      ST_SRCHK  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // response register frees up when taken
   wire logic out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = !stat.clear_done;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            // read issued for every command: counting, single reads and crossing search
            cmd.rd_issue = 1'b1;
            if (stat.command == CMD_CROSS) begin
               cmd.search_start = 1'b1;
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.inc_write    = stat.hit;
               cmd.frame_update = 1'b1;
               cmd.rsp_load     = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            state_in = ST_SRCHK;
         end
         ST_SRCHK: begin
            if (stat.search_hit || stat.search_last) begin
               if (out_free) begin
                  cmd.rsp_load = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.search_step = 1'b1;
               state_in        = ST_SEARCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/hrh_datapath.sv
// framing, decode, counter memory and crossing search
`timescale 1ns / 1ps
`default_nettype none
module hrh_datapath
   import hrh_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire req_type          req,
   input  wire logic             csr_write,
   input  wire logic [0:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_data,
   input  wire cmd_type          cmd,
   output status_type            stat,
   output rsp_type               rsp
);

   logic [COUNT_WIDTH-1:0] mem [DEPTH];
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   req_type     req_ff;
   logic [15:0] level_ff;
   logic [6:0]  amps_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic        clr_done_ff;

   phase_type   phase_ff, phase_in;
   logic [31:0] left_ff, left_in;
   logic [1:0]  pos_ff, pos_in;
   logic        is_data_ff, is_data_in;
   logic        ones1_ff, ones1_in;

   logic [AMP_W:0] samp_ff;
   rsp_type     rsp_ff, rsp_in;

   // decode of the latched word
   wire logic [31:0] w = req_ff.word;
   wire logic [4:0] chip  = w[6:2];
   wire logic       board = w[7];
   wire logic [6:0] chan  = {w[8], w[15:10]};
   wire logic [5:0] amp   = w[22:17];
   wire logic [6:0] bco   = {w[9], w[28:23]};
   wire logic [2:0] adc   = {w[1], w[31:30]};

   // framing next state and kind
   kind_type kind;
   logic     word_data;
   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      pos_in     = pos_ff;
      is_data_in = is_data_ff;
      ones1_in   = ones1_ff;
      kind       = KIND_CHECK;
      unique case (phase_ff)
         PH_HEADER: begin
            kind       = KIND_HEADER;
            left_in    = w;
            pos_in     = 2'd0;
            is_data_in = (w != 32'd4);
            ones1_in   = 1'b0;
            phase_in   = (w == 32'd0) ? PH_CHECK : PH_BODY;
         end
         PH_BODY: begin
            if (is_data_ff) begin
               if (pos_ff == 2'd0) ones1_in = (w == '1);
               else if (pos_ff == 2'd1 && ones1_ff && w == '1) is_data_in = 1'b0;
            end
            kind = is_data_in ? KIND_DATA : KIND_SKIP;
            if (pos_ff < 2'd2) pos_in = pos_ff + 2'd1;
            left_in = left_ff - 32'd1;
            if (left_in == 32'd0) phase_in = PH_CHECK;
         end
         default: begin
            kind     = KIND_CHECK;
            phase_in = PH_HEADER;
         end
      endcase
      word_data = (phase_ff == PH_BODY) && is_data_in;
   end

   // hit address, slot = board*13 + chip - 1
   wire logic [5:0] slot_w = {5'd0, board} * 6'd13 + {1'b0, chip} - 6'd1;
   wire logic hit_ok = (bco == 7'd0) && (chip != 5'd0) && (chip < 5'd14)
                     && ({1'b0, slot_w} < 7'(CHIP_SLOTS)) && ({1'b0, chan} < 8'(CHANNELS))
                     && ({1'b0, amp} < 7'(AMPLITUDE_STEPS));
   wire logic hit = (req_ff.command == CMD_WORD) && word_data && hit_ok;

   wire logic q_ok = ({1'b0, req_ff.query_chip} < 6'(CHIP_SLOTS))
                   && ({1'b0, req_ff.query_channel} < 8'(CHANNELS));
   wire logic qa_ok = ({1'b0, req_ff.query_amplitude} < 7'(AMPLITUDE_STEPS));

   logic [ADDR_W-1:0] hit_addr, q_addr, s_addr, rd_addr;
   assign hit_addr = ADDR_W'((slot_w[SLOT_W-1:0] * CHANNELS + chan[CHAN_W-1:0])
                             * AMPLITUDE_STEPS + amp[AMP_W-1:0]);
   assign q_addr = ADDR_W'((req_ff.query_chip[SLOT_W-1:0] * CHANNELS
                            + req_ff.query_channel[CHAN_W-1:0]) * AMPLITUDE_STEPS
                           + req_ff.query_amplitude[AMP_W-1:0]);
   assign s_addr = ADDR_W'((req_ff.query_chip[SLOT_W-1:0] * CHANNELS
                            + req_ff.query_channel[CHAN_W-1:0]) * AMPLITUDE_STEPS
                           + samp_ff[AMP_W-1:0]);

   always_comb begin
      case (req_ff.command)
         CMD_WORD: rd_addr = hit_addr;
         CMD_READ: rd_addr = q_addr;
         default:  rd_addr = s_addr;
      endcase
   end

   // search bound: min(amplitudes_in_use, AMPLITUDE_STEPS)
   wire logic [6:0] n_lim = (amps_ff > 7'(AMPLITUDE_STEPS)) ? 7'(AMPLITUDE_STEPS) : amps_ff;
   wire logic s_in_range = q_ok && (samp_ff < n_lim);
   wire logic s_hit = s_in_range && ({{(32-COUNT_WIDTH){1'b0}}, rd_data_ff} > {16'd0, level_ff});
   wire logic [6:0] s_next = samp_ff + 7'd1;
   wire logic s_last = !s_in_range || (s_next >= n_lim);

   // memory: one write port, one registered read
   logic rd_en_ff;
   always_ff @(posedge clock) begin
      if (cmd.clear_en)
         mem[clr_ff] <= '0;
      else if (cmd.inc_write && rd_data_ff != COUNT_MAX)
         mem[hit_addr] <= rd_data_ff + 1'b1;
      if (rd_en_ff) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         level_ff    <= 16'd50;
         amps_ff     <= 7'd64;
         phase_ff    <= PH_HEADER;
         left_ff     <= '0;
         pos_ff      <= '0;
         is_data_ff  <= 1'b0;
         ones1_ff    <= 1'b0;
         rd_en_ff    <= 1'b0;
      end else begin
         if (cmd.clear_en) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) clr_done_ff <= 1'b1;
         end
         if (csr_write) begin
            if (csr_index == CSR_LEVEL) level_ff <= csr_data;
            else                        amps_ff  <= csr_data[6:0];
         end
         if (cmd.frame_update && req_ff.command == CMD_WORD) begin
            phase_ff   <= phase_in;
            left_ff    <= left_in;
            pos_ff     <= pos_in;
            is_data_ff <= is_data_in;
            ones1_ff   <= ones1_in;
         end
         // read launches in the cycle after the request, with address stable
         rd_en_ff <= cmd.rd_issue || cmd.search_step || cmd.search_start;
      end
   end

   always_comb begin
      rsp_in = '0;
      case (req_ff.command)
         CMD_WORD: begin
            rsp_in.record_kind = kind;
            rsp_in.hit_counted = hit;
            rsp_in.chip_id     = chip;
            rsp_in.board_id    = board;
            rsp_in.channel_id  = chan;
            rsp_in.amplitude   = amp;
            rsp_in.crossing_id = bco;
            rsp_in.adc_value   = adc;
         end
         CMD_READ:
            rsp_in.count_value = (q_ok && qa_ok) ? 16'(rd_data_ff) : 16'd0;
         CMD_CROSS: begin
            rsp_in.found              = s_hit;
            rsp_in.crossing_amplitude = s_hit ? 6'(samp_ff) : 6'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req;
      if (cmd.search_start) samp_ff <= '0;
      else if (cmd.search_step) samp_ff <= s_next[AMP_W:0];
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   assign stat.clear_done  = clr_done_ff;
   assign stat.command     = req_ff.command;
   assign stat.hit         = hit;
   assign stat.search_last = s_last;
   assign stat.search_hit  = s_hit;
   assign rsp = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/core/hit_record_histogrammer_core.sv
// top level of the hit record histogrammer
//  channel | direction | handshake         | payload
//  req     | in        | valid/ready       | command, word, query fields
//  rsp     | out       | valid/ready       | record kind, decode, count, crossing
//  csr     | in        | write enable only | index, 16-bit data
// A stream word or counter read passes through latch, read address, registered
// memory read, then read-modify-write for a counted hit, and response. A crossing
// search makes one memory read for each amplitude examined.
// After reset a clearing pass writes zero to all 212992 counters, one a cycle;
// requests wait until it ends. A stalled response holds the next finish.
`timescale 1ns / 1ps
`default_nettype none
module hit_record_histogrammer_core
   import hrh_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   hrh_stream_if.sink            req,
   hrh_stream_if.source          rsp,
   input  wire logic             csr_write,
   input  wire logic [0:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type stat;

   hrh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hrh_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req.payload),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp       (rsp.payload)
   );

endmodule
`default_nettype wire
